// ===== rtl/core/rsdm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsdm_pkg
// Shared types and constants of the relay switch delay meter.
// ----------------------------------------------------------------------------
package rsdm_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 31;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StepW  = 5;

  localparam logic [TimeW-1:0]  ToggleReset   = 32'd5000000;
  localparam logic [TimeW-1:0]  DebounceReset = 32'd20000;
  localparam logic [CountW-1:0] CountMax      = {CountW{1'b1}};
  localparam logic [StepW-1:0]  LastStep      = {StepW{1'b1}};

  // register index, taken from paddr[2]
  localparam logic RegToggle   = 1'b0;
  localparam logic RegDebounce = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] flip_interval;
    logic [TimeW-1:0] edge_holdoff;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [TimeW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [TimeW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/rsdm_cfg.sv =====
// ----------------------------------------------------------------------------
// rsdm_cfg
// APB-style register file holding the toggle and debounce periods.
// ----------------------------------------------------------------------------
module rsdm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsdm_pkg::AddrW-1:0]  paddr,
  input  logic [rsdm_pkg::DataW-1:0]  pwdata,
  output logic [rsdm_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output rsdm_pkg::cfg_t              cfg_o
);

  logic [rsdm_pkg::TimeW-1:0] toggle_q, toggle_d;
  logic [rsdm_pkg::TimeW-1:0] debounce_q, debounce_d;
  logic                       wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    toggle_d   = toggle_q;
    debounce_d = debounce_q;
    if (wr_en) begin
      unique case (paddr[2])
        rsdm_pkg::RegToggle:   toggle_d   = pwdata;
        rsdm_pkg::RegDebounce: debounce_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rsdm_pkg::RegToggle:   prdata = toggle_q;
      rsdm_pkg::RegDebounce: prdata = debounce_q;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q   <= rsdm_pkg::ToggleReset;
      debounce_q <= rsdm_pkg::DebounceReset;
    end else begin
      toggle_q   <= toggle_d;
      debounce_q <= debounce_d;
    end
  end

  assign cfg_o.flip_interval = toggle_q;
  assign cfg_o.edge_holdoff  = debounce_q;

endmodule

// ===== rtl/core/rsdm_div.sv =====
// ----------------------------------------------------------------------------
// rsdm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsdm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsdm_pkg::div_req_t req_i,
  output rsdm_pkg::div_rsp_t rsp_o
);

  logic [rsdm_pkg::TimeW-1:0]  rem_q, rem_d;
  logic [rsdm_pkg::TimeW-1:0]  quo_q, quo_d;
  logic [rsdm_pkg::CountW-1:0] dvs_q, dvs_d;
  logic [rsdm_pkg::StepW-1:0]  step_q, step_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [rsdm_pkg::TimeW-1:0]  trial;
  logic                        fits;

  assign trial = {rem_q[rsdm_pkg::TimeW-2:0], quo_q[rsdm_pkg::TimeW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? (trial - {1'b0, dvs_q}) : trial;
      quo_d  = {quo_q[rsdm_pkg::TimeW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == rsdm_pkg::LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && step_q == rsdm_pkg::LastStep) |=> done_q)
    else $error("divider missed done");
`endif

endmodule

// ===== rtl/core/relay_switch_delay_meter_core.sv =====
// ----------------------------------------------------------------------------
// relay_switch_delay_meter_core
// Measures relay switch delays from microsecond ticks and drives the relay.
//
// One input transfer is one microsecond tick carrying edge_seen_i, set when
// the readback line changed during the tick. Every tick yields exactly one
// output transfer: the drive level after the tick and, when a readback edge
// passed the debounce check, a report with edge time, toggle time, delay,
// saturating per-direction count and average delay. Without a report the
// report fields read zero.
// A tick passes through the edge, delay and toggle states to the final state;
// with a report it also passes the sum state and waits in the divide state
// while the bit-serial divider computes the average. The block takes no new
// tick until the current one has been loaded into the output register, which
// holds the result while out_ready_i is low; a tick may be accepted meanwhile,
// and its result waits in the final state. Reset restarts the time counter at
// zero with the drive high, clears the per-direction counts and sums and loads
// the default periods (5000000 and 20000 us). The user must write the periods
// over the APB port only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module relay_switch_delay_meter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsdm_pkg::AddrW-1:0]  paddr,
  input  logic [rsdm_pkg::DataW-1:0]  pwdata,
  output logic [rsdm_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        edge_seen_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        drive_level_o,
  output logic                        report_valid_o,
  output logic                        report_to_high_o,
  output logic [rsdm_pkg::TimeW-1:0]  edge_time_o,
  output logic [rsdm_pkg::TimeW-1:0]  toggle_time_o,
  output logic [rsdm_pkg::TimeW-1:0]  switch_delay_o,
  output logic [rsdm_pkg::CountW-1:0] event_count_o,
  output logic [rsdm_pkg::TimeW-1:0]  average_delay_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StEdge  = 3'd1;
  localparam logic [2:0] StDelay = 3'd2;
  localparam logic [2:0] StSum   = 3'd3;
  localparam logic [2:0] StTog   = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

  rsdm_pkg::cfg_t     cfg;
  rsdm_pkg::div_req_t div_req;
  rsdm_pkg::div_rsp_t div_rsp;

  logic [2:0] st_q, st_d;

  // long-lived state
  logic [rsdm_pkg::TimeW-1:0]  time_q, time_d;
  logic                        drive_q, drive_d;
  logic [rsdm_pkg::TimeW-1:0]  last_tog_q, last_tog_d;
  logic [rsdm_pkg::TimeW-1:0]  last_hi_q, last_hi_d;
  logic [rsdm_pkg::TimeW-1:0]  last_lo_q, last_lo_d;
  logic [rsdm_pkg::TimeW-1:0]  last_edge_q, last_edge_d;
  logic [rsdm_pkg::CountW-1:0] hi_cnt_q, hi_cnt_d;
  logic [rsdm_pkg::CountW-1:0] lo_cnt_q, lo_cnt_d;
  logic [rsdm_pkg::TimeW-1:0]  hi_sum_q, hi_sum_d;
  logic [rsdm_pkg::TimeW-1:0]  lo_sum_q, lo_sum_d;

  // current tick
  logic                        edge_q, edge_d;
  logic                        rep_q, rep_d;
  logic                        to_high_q, to_high_d;
  logic [rsdm_pkg::TimeW-1:0]  etime_q, etime_d;
  logic [rsdm_pkg::TimeW-1:0]  ttime_q, ttime_d;
  logic [rsdm_pkg::TimeW-1:0]  delay_q, delay_d;
  logic [rsdm_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [rsdm_pkg::TimeW-1:0]  sum_q, sum_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        o_drive_q, o_drive_d;
  logic                        o_rep_q, o_rep_d;
  logic                        o_to_high_q, o_to_high_d;
  logic [rsdm_pkg::TimeW-1:0]  o_etime_q, o_etime_d;
  logic [rsdm_pkg::TimeW-1:0]  o_ttime_q, o_ttime_d;
  logic [rsdm_pkg::TimeW-1:0]  o_delay_q, o_delay_d;
  logic [rsdm_pkg::CountW-1:0] o_cnt_q, o_cnt_d;
  logic [rsdm_pkg::TimeW-1:0]  o_avg_q, o_avg_d;

  logic [rsdm_pkg::TimeW-1:0]  arith_diff;
  logic [rsdm_pkg::CountW-1:0] cnt_sel;
  logic [rsdm_pkg::CountW-1:0] cnt_inc;
  logic [rsdm_pkg::TimeW-1:0]  sum_new;

  rsdm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rsdm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (st_q == StIdle);

  assign cnt_sel = to_high_q ? hi_cnt_q : lo_cnt_q;
  assign cnt_inc = (cnt_sel == rsdm_pkg::CountMax) ? cnt_sel : cnt_sel + 1'b1;
  assign sum_new = (to_high_q ? hi_sum_q : lo_sum_q) + delay_q;

  always_comb begin
    unique case (st_q)
      StEdge:  arith_diff = time_q - last_edge_q;
      StDelay: arith_diff = etime_q - ttime_q;
      default: arith_diff = time_q - last_tog_q;
    endcase
  end

  always_comb begin
    st_d        = st_q;
    time_d      = time_q;
    drive_d     = drive_q;
    last_tog_d  = last_tog_q;
    last_hi_d   = last_hi_q;
    last_lo_d   = last_lo_q;
    last_edge_d = last_edge_q;
    hi_cnt_d    = hi_cnt_q;
    lo_cnt_d    = lo_cnt_q;
    hi_sum_d    = hi_sum_q;
    lo_sum_d    = lo_sum_q;
    edge_d      = edge_q;
    rep_d       = rep_q;
    to_high_d   = to_high_q;
    etime_d     = etime_q;
    ttime_d     = ttime_q;
    delay_d     = delay_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_drive_d   = o_drive_q;
    o_rep_d     = o_rep_q;
    o_to_high_d = o_to_high_q;
    o_etime_d   = o_etime_q;
    o_ttime_d   = o_ttime_q;
    o_delay_d   = o_delay_q;
    o_cnt_d     = o_cnt_q;
    o_avg_d     = o_avg_q;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    div_req.divisor  = cnt_q;

    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          edge_d = edge_seen_i;
          st_d   = StEdge;
        end
      end
      StEdge: begin
        rep_d     = edge_q && (arith_diff > cfg.edge_holdoff);
        to_high_d = drive_q;
        etime_d   = time_q;
        ttime_d   = drive_q ? last_hi_q : last_lo_q;
        if (rep_d) begin
          last_edge_d = time_q;
        end
        st_d = StDelay;
      end
      StDelay: begin
        delay_d = arith_diff;
        st_d    = rep_q ? StSum : StTog;
      end
      StSum: begin
        cnt_d = cnt_inc;
        sum_d = sum_new;
        if (to_high_q) begin
          hi_cnt_d = cnt_inc;
          hi_sum_d = sum_new;
        end else begin
          lo_cnt_d = cnt_inc;
          lo_sum_d = sum_new;
        end
        st_d = StTog;
      end
      StTog: begin
        if (arith_diff > cfg.flip_interval) begin
          drive_d    = !drive_q;
          last_tog_d = time_q;
          if (!drive_q) begin
            last_hi_d = time_q;
          end else begin
            last_lo_d = time_q;
          end
        end
        time_d = time_q + 1'b1;
        if (rep_q) begin
          div_req.start = 1'b1;
          st_d          = StDiv;
        end else begin
          st_d = StFin;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          st_d = StFin;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_drive_d   = drive_q;
          o_rep_d     = rep_q;
          o_to_high_d = rep_q & to_high_q;
          o_etime_d   = rep_q ? etime_q : '0;
          o_ttime_d   = rep_q ? ttime_q : '0;
          o_delay_d   = rep_q ? delay_q : '0;
          o_cnt_d     = rep_q ? cnt_q : '0;
          o_avg_d     = rep_q ? div_rsp.quotient : '0;
          st_d        = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      time_q      <= '0;
      drive_q     <= 1'b1;
      last_tog_q  <= '0;
      last_hi_q   <= '0;
      last_lo_q   <= '0;
      last_edge_q <= '0;
      hi_cnt_q    <= '0;
      lo_cnt_q    <= '0;
      hi_sum_q    <= '0;
      lo_sum_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      time_q      <= time_d;
      drive_q     <= drive_d;
      last_tog_q  <= last_tog_d;
      last_hi_q   <= last_hi_d;
      last_lo_q   <= last_lo_d;
      last_edge_q <= last_edge_d;
      hi_cnt_q    <= hi_cnt_d;
      lo_cnt_q    <= lo_cnt_d;
      hi_sum_q    <= hi_sum_d;
      lo_sum_q    <= lo_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q      <= edge_d;
    rep_q       <= rep_d;
    to_high_q   <= to_high_d;
    etime_q     <= etime_d;
    ttime_q     <= ttime_d;
    delay_q     <= delay_d;
    cnt_q       <= cnt_d;
    sum_q       <= sum_d;
    o_drive_q   <= o_drive_d;
    o_rep_q     <= o_rep_d;
    o_to_high_q <= o_to_high_d;
    o_etime_q   <= o_etime_d;
    o_ttime_q   <= o_ttime_d;
    o_delay_q   <= o_delay_d;
    o_cnt_q     <= o_cnt_d;
    o_avg_q     <= o_avg_d;
  end

  assign out_valid_o      = out_valid_q;
  assign drive_level_o    = o_drive_q;
  assign report_valid_o   = o_rep_q;
  assign report_to_high_o = o_to_high_q;
  assign edge_time_o      = o_etime_q;
  assign toggle_time_o    = o_ttime_q;
  assign switch_delay_o   = o_delay_q;
  assign event_count_o    = o_cnt_q;
  assign average_delay_o  = o_avg_q;

`ifndef SYNTHESIS
  a_report_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_rep_q) |-> (o_cnt_q != '0))
    else $error("report with zero count");

  a_report_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_rep_q) |-> (o_delay_q == o_etime_q - o_ttime_q))
    else $error("switch delay mismatch");

  a_no_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !o_rep_q) |-> (o_cnt_q == '0 && o_avg_q == '0 && !o_to_high_q))
    else $error("report fields not cleared");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (st_q == StDiv))
    else $error("divider busy outside divide state");
`endif

endmodule
